### hdl/adi_pkg.sv
package adi_pkg;

    // number formats
    localparam int FRAC_BITS   = 48;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_W      = 64;
    localparam int FAC_W       = 32;
    localparam int SMP_W       = 16;
    localparam int SCL_SHIFT   = FRAC_BITS - FAC_W;
    localparam int PROD_W      = SAMPLE_BITS + FAC_W + 1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] SCL_LIM = SAT_MAX >>> SCL_SHIFT;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CH1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CH2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_WGT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_DECAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_DECAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd5;

    // micro-program length and step counter width
    localparam int STEPS = 22;
    localparam int PC_W  = $clog2(STEPS);

    typedef enum logic [2:0] {
        OP_NOP, OP_SCALE, OP_ADD, OP_SUB, OP_MULA, OP_MULB, OP_HALF
    } t_op;

    // lane working registers
    typedef enum logic [2:0] {
        R_RAW, R_BIAS, R_VEL, R_POS, R_ACC, R_ADT, R_TMP, R_HALF
    } t_reg;

    // Q0.32 factor selection
    typedef enum logic [1:0] {
        F_WGT, F_DT, F_VDEC, F_PDEC
    } t_fsel;

    typedef enum logic [1:0] {
        J_NEXT, J_WAIT_IN, J_WAIT_OUT, J_HOME
    } t_jmp;

    typedef struct packed {
        t_op   op;
        t_reg  sa;
        t_reg  sb;
        t_fsel fsel;
        t_reg  dst;
        t_jmp  jmp;
    } t_uop;

    // sequencer status towards the top level
    typedef struct packed {
        t_uop uop;
        logic take;
        logic publish;
    } t_seq_ctl;

    // factors shared by both lanes
    typedef struct packed {
        logic [FAC_W-1:0] wgt;
        logic [FAC_W-1:0] dt;
        logic [FAC_W-1:0] vdec;
        logic [FAC_W-1:0] pdec;
    } t_fac;

    function automatic t_uop mk(t_op op, t_reg sa, t_reg sb, t_fsel f, t_reg dst,
                                t_jmp jmp);
        t_uop u;
        u.op   = op;
        u.sa   = sa;
        u.sb   = sb;
        u.fsel = f;
        u.dst  = dst;
        u.jmp  = jmp;
        return u;
    endfunction

    // micro-program ROM, one control word per step
    function automatic t_uop rom(logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = mk(OP_NOP,   R_RAW,  R_RAW,  F_WGT,  R_RAW,  J_WAIT_IN);
            5'd1:  u = mk(OP_SCALE, R_RAW,  R_RAW,  F_WGT,  R_RAW,  J_NEXT);
            // bias += w * (raw - bias)
            5'd2:  u = mk(OP_SUB,   R_RAW,  R_BIAS, F_WGT,  R_TMP,  J_NEXT);
            5'd3:  u = mk(OP_MULA,  R_TMP,  R_TMP,  F_WGT,  R_TMP,  J_NEXT);
            5'd4:  u = mk(OP_MULB,  R_TMP,  R_TMP,  F_WGT,  R_TMP,  J_NEXT);
            5'd5:  u = mk(OP_ADD,   R_BIAS, R_TMP,  F_WGT,  R_BIAS, J_NEXT);
            5'd6:  u = mk(OP_SUB,   R_RAW,  R_BIAS, F_WGT,  R_ACC,  J_NEXT);
            // a*dt
            5'd7:  u = mk(OP_MULA,  R_ACC,  R_ACC,  F_DT,   R_ADT,  J_NEXT);
            5'd8:  u = mk(OP_MULB,  R_ACC,  R_ACC,  F_DT,   R_ADT,  J_NEXT);
            // leaky velocity
            5'd9:  u = mk(OP_ADD,   R_VEL,  R_ADT,  F_VDEC, R_TMP,  J_NEXT);
            5'd10: u = mk(OP_MULA,  R_TMP,  R_TMP,  F_VDEC, R_VEL,  J_NEXT);
            5'd11: u = mk(OP_MULB,  R_TMP,  R_TMP,  F_VDEC, R_VEL,  J_NEXT);
            // a*dt*dt/2
            5'd12: u = mk(OP_MULA,  R_ADT,  R_ADT,  F_DT,   R_HALF, J_NEXT);
            5'd13: u = mk(OP_MULB,  R_ADT,  R_ADT,  F_DT,   R_HALF, J_NEXT);
            5'd14: u = mk(OP_HALF,  R_HALF, R_HALF, F_DT,   R_HALF, J_NEXT);
            // leaky position
            5'd15: u = mk(OP_MULA,  R_VEL,  R_VEL,  F_DT,   R_TMP,  J_NEXT);
            5'd16: u = mk(OP_MULB,  R_VEL,  R_VEL,  F_DT,   R_TMP,  J_NEXT);
            5'd17: u = mk(OP_ADD,   R_TMP,  R_HALF, F_DT,   R_TMP,  J_NEXT);
            5'd18: u = mk(OP_ADD,   R_POS,  R_TMP,  F_PDEC, R_TMP,  J_NEXT);
            5'd19: u = mk(OP_MULA,  R_TMP,  R_TMP,  F_PDEC, R_POS,  J_NEXT);
            5'd20: u = mk(OP_MULB,  R_TMP,  R_TMP,  F_PDEC, R_POS,  J_NEXT);
            // hand the word to the output register
            5'd21: u = mk(OP_NOP,   R_RAW,  R_RAW,  F_WGT,  R_RAW,  J_WAIT_OUT);
            default: u = mk(OP_NOP, R_RAW,  R_RAW,  F_WGT,  R_RAW,  J_HOME);
        endcase
        return u;
    endfunction

    // saturating add and subtract
    function automatic logic signed [DATA_W-1:0] sat_add(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

### hdl/accel_double_integrator_unit.sv
// Two-channel accelerometer integrator. Each input word carries one stereo frame;
// each channel is scaled to Q16.48, has a slow moving-average bias removed and is
// integrated into a leaky velocity and leaky position, all sums saturating. One
// output word follows each frame with acceleration, velocity and position of both
// channels plus running peak and trough of channel-2 position and raw acceleration
// (all starting at zero). The input is ready again in the cycle after the result
// word is written, so a new frame is taken only once the last one is through
// its steps: a 22-step micro-program drives both channel lanes in step, and
// each 64 x 32 bit fractional product takes two of those steps, one per 32-bit half
// of the operand. A new frame is accepted while the previous result still sits in
// the output register; the last step waits only if that result has not left by
// then. Configuration writes belong between frames.
module accel_double_integrator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [adi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adi_pkg::FAC_W-1:0]        i_cfg_data,
    // input frames
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [31:0]                      i_s_axis_tdata,  // sample_ch1, sample_ch2
    // results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // accel_ch1, accel_ch2, velocity_ch1, velocity_ch2, position_ch1,
    // position_ch2, peak_position_ch2, trough_position_ch2,
    // peak_raw_accel_ch2, trough_raw_accel_ch2
    output logic [639:0]                     o_m_axis_tdata
);
    import adi_pkg::*;

    logic [FAC_W-1:0] r_scale1, r_scale2;
    t_fac             r_fac;

    logic signed [SMP_W-1:0]  r_smp1, r_smp2;
    logic signed [DATA_W-1:0] r_max_pos, r_min_pos, r_max_acc, r_min_acc;
    logic signed [DATA_W-1:0] n_max_pos, n_min_pos, n_max_acc, n_min_acc;
    logic                     r_out_valid;
    logic [639:0]             r_out_data;

    t_seq_ctl                 ctl;
    logic                     out_free;
    logic signed [DATA_W-1:0] raw1, acc1, vel1, pos1;
    logic signed [DATA_W-1:0] raw2, acc2, vel2, pos2;

    assign out_free = !r_out_valid || i_m_axis_tready;

    adi_useq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    adi_lane u_lane1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uop    (ctl.uop),
        .i_sample (r_smp1),
        .i_scale  (r_scale1),
        .i_fac    (r_fac),
        .o_raw    (raw1),
        .o_accel  (acc1),
        .o_vel    (vel1),
        .o_pos    (pos1)
    );

    adi_lane u_lane2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uop    (ctl.uop),
        .i_sample (r_smp2),
        .i_scale  (r_scale2),
        .i_fac    (r_fac),
        .o_raw    (raw2),
        .o_accel  (acc2),
        .o_vel    (vel2),
        .o_pos    (pos2)
    );

    assign o_s_axis_tready = ctl.take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale1   <= 32'd1257926;
            r_scale2   <= 32'd1272583;
            r_fac.wgt  <= 32'd42950;
            r_fac.vdec <= 32'd4294924346;
            r_fac.pdec <= 32'd4294967253;
            r_fac.dt   <= 32'd536871;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE_CH1: r_scale1   <= i_cfg_data;
                CFG_SCALE_CH2: r_scale2   <= i_cfg_data;
                CFG_BIAS_WGT:  r_fac.wgt  <= i_cfg_data;
                CFG_VEL_DECAY: r_fac.vdec <= i_cfg_data;
                CFG_POS_DECAY: r_fac.pdec <= i_cfg_data;
                CFG_TIME_STEP: r_fac.dt   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture the frame
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && ctl.take) begin
            r_smp1 <= i_s_axis_tdata[15:0];
            r_smp2 <= i_s_axis_tdata[31:16];
        end
    end

    // channel-2 extrema
    always_comb begin
        n_max_pos = (pos2 > r_max_pos) ? pos2 : r_max_pos;
        n_min_pos = (pos2 < r_min_pos) ? pos2 : r_min_pos;
        n_max_acc = (raw2 > r_max_acc) ? raw2 : r_max_acc;
        n_min_acc = (raw2 < r_min_acc) ? raw2 : r_min_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pos <= '0;
            r_min_pos <= '0;
            r_max_acc <= '0;
            r_min_acc <= '0;
        end else if (ctl.publish) begin
            r_max_pos <= n_max_pos;
            r_min_pos <= n_min_pos;
            r_max_acc <= n_max_acc;
            r_min_acc <= n_min_acc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.publish) begin
            r_out_data <= {n_min_acc, n_max_acc, n_min_pos, n_max_pos,
                           pos2, pos1, vel2, vel1, acc2, acc1};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### hdl/adi_useq.sv
module adi_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    output adi_pkg::t_seq_ctl o_ctl
);
    import adi_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uop            uop;

    assign uop = rom(r_pc);

    // next step: fall through, wait on a condition or go home
    always_comb begin
        case (uop.jmp)
            J_NEXT:     n_pc = PC_W'(r_pc + 1'b1);
            J_WAIT_IN:  n_pc = i_in_valid ? PC_W'(r_pc + 1'b1) : r_pc;
            J_WAIT_OUT: n_pc = i_out_free ? '0 : r_pc;
            default:    n_pc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.uop     = uop;
    assign o_ctl.take    = (uop.jmp == J_WAIT_IN);
    assign o_ctl.publish = (uop.jmp == J_WAIT_OUT) && i_out_free;

endmodule

### hdl/adi_lane.sv
module adi_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  adi_pkg::t_uop                        i_uop,
    input  logic signed [adi_pkg::SMP_W-1:0]     i_sample,
    input  logic [adi_pkg::FAC_W-1:0]            i_scale,
    input  adi_pkg::t_fac                        i_fac,
    output logic signed [adi_pkg::DATA_W-1:0]    o_raw,
    output logic signed [adi_pkg::DATA_W-1:0]    o_accel,
    output logic signed [adi_pkg::DATA_W-1:0]    o_vel,
    output logic signed [adi_pkg::DATA_W-1:0]    o_pos
);
    import adi_pkg::*;

    // working registers; bias, velocity and position are the lane state
    logic signed [DATA_W-1:0] r_raw, r_bias, r_vel, r_pos, r_acc, r_adt, r_tmp, r_half;
    // product halves between the two multiply steps
    logic [DATA_W-1:0]        r_mag;
    logic                     r_neg;
    logic [FAC_W-1:0]         r_plo;

    logic signed [DATA_W-1:0] opa, opb, n_res;
    logic [FAC_W-1:0]         fac;
    logic [DATA_W-1:0]        mag, lo_prod, hi_sum;
    logic signed [PROD_W-1:0] scl_prod;
    logic signed [DATA_W-1:0] scl_ext;
    logic                     wr_en;

    // operand selection
    always_comb begin
        case (i_uop.sa)
            R_RAW:   opa = r_raw;
            R_BIAS:  opa = r_bias;
            R_VEL:   opa = r_vel;
            R_POS:   opa = r_pos;
            R_ACC:   opa = r_acc;
            R_ADT:   opa = r_adt;
            R_TMP:   opa = r_tmp;
            default: opa = r_half;
        endcase
        case (i_uop.sb)
            R_RAW:   opb = r_raw;
            R_BIAS:  opb = r_bias;
            R_VEL:   opb = r_vel;
            R_POS:   opb = r_pos;
            R_ACC:   opb = r_acc;
            R_ADT:   opb = r_adt;
            R_TMP:   opb = r_tmp;
            default: opb = r_half;
        endcase
        case (i_uop.fsel)
            F_WGT:   fac = i_fac.wgt;
            F_DT:    fac = i_fac.dt;
            F_VDEC:  fac = i_fac.vdec;
            default: fac = i_fac.pdec;
        endcase
    end

    // raw count times scale, then moved up to the Q16.48 point
    assign scl_prod = PROD_W'($signed(i_sample[SAMPLE_BITS-1:0]))
                      * $signed({1'b0, i_scale});
    assign scl_ext  = DATA_W'(scl_prod);

    // first multiply half: low word of the magnitude
    assign mag     = opa[DATA_W-1] ? DATA_W'(-opa) : DATA_W'(opa);
    assign lo_prod = DATA_W'(mag[FAC_W-1:0]) * DATA_W'(fac);
    // second half: high word plus carry-in from the low product
    assign hi_sum  = DATA_W'(r_mag[DATA_W-1:FAC_W]) * DATA_W'(fac) + DATA_W'(r_plo);

    // result of the step
    always_comb begin
        wr_en = 1'b1;
        n_res = opa;
        case (i_uop.op)
            OP_SCALE: begin
                if (scl_ext > SCL_LIM) begin
                    n_res = SAT_MAX;
                end else if (scl_ext < -SCL_LIM - 1) begin
                    n_res = SAT_MIN;
                end else begin
                    n_res = scl_ext <<< SCL_SHIFT;
                end
            end
            OP_ADD:  n_res = sat_add(opa, opb);
            OP_SUB:  n_res = sat_sub(opa, opb);
            OP_MULB: n_res = r_neg ? -$signed(hi_sum) : $signed(hi_sum);
            // halve, rounding toward zero
            OP_HALF: n_res = $signed(opa + DATA_W'(opa[DATA_W-1])) >>> 1;
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_uop.op == OP_MULA) begin
            r_mag <= mag;
            r_neg <= opa[DATA_W-1];
            r_plo <= lo_prod[DATA_W-1:FAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (i_uop.dst)
                R_RAW:   r_raw  <= n_res;
                R_ACC:   r_acc  <= n_res;
                R_ADT:   r_adt  <= n_res;
                R_TMP:   r_tmp  <= n_res;
                R_HALF:  r_half <= n_res;
                default: ;
            endcase
        end
    end

    // lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
            r_vel  <= '0;
            r_pos  <= '0;
        end else if (wr_en) begin
            case (i_uop.dst)
                R_BIAS:  r_bias <= n_res;
                R_VEL:   r_vel  <= n_res;
                R_POS:   r_pos  <= n_res;
                default: ;
            endcase
        end
    end

    assign o_raw   = r_raw;
    assign o_accel = r_acc;
    assign o_vel   = r_vel;
    assign o_pos   = r_pos;

endmodule
